// File: sv/nms_pkg.sv
// Shared constants, types and the sigmoid lookup table for the neuron block.
// Depends on nothing; used by neuron_mac_sigmoid.
package nms_pkg;

  localparam int MAX_INPUTS_DEF = 16;

  // Request fields
  localparam int WIDX_W    = 4;
  localparam int WSLOTS    = 16;
  localparam int VAL_W     = 16;
  localparam int S_TDATA_W = 24;

  // Datapath widths
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 40;
  localparam int FRAC_W = 12;

  // Activation table
  localparam int ACT_W     = 16;
  localparam int ROM_DEPTH = 512;
  localparam int ROM_IDX_W = 9;

  // Configuration port
  localparam int APB_DW  = 32;
  localparam int PADDR_W = 3;
  localparam int REG_W   = PADDR_W - 2;
  localparam logic [REG_W-1:0] REG_BIAS = '0;

  // Operation codes carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FEED  = 1'b1;

  typedef logic [ACT_W-1:0] act_rom_t [ROM_DEPTH];

  // Unsigned 64-bit quotient by restoring shift and subtract. Only used while
  // the table is built at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] dividend,
                                         input logic [63:0] divisor);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], dividend[i]};
      if (rem >= {1'b0, divisor}) begin
        rem    = rem - {1'b0, divisor};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Builds round(65535 / (1 + exp(-k/32))) for k = -256..255 using exact integer
  // arithmetic with 60 fractional bits. Evaluated once at elaboration.
  function automatic act_rom_t build_act_rom();
    act_rom_t     rom;
    logic [63:0]  e [257];
    logic [63:0]  step;
    logic [63:0]  term;
    logic [63:0]  e40;
    logic [63:0]  d40;
    logic [63:0]  num;
    logic [63:0]  v;
    logic [127:0] prod;
    int           m;
    step = 64'd1 << 60;
    term = 64'd1 << 60;
    // Series for exp(-1/32).
    for (int n = 1; n < 16; n++) begin
      term = udiv64(term, 64'd32 * 64'(n));
      if ((n & 1) != 0) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    e[0] = 64'd1 << 60;
    for (int k = 1; k <= 256; k++) begin
      prod = {64'd0, e[k-1]} * {64'd0, step};
      e[k] = prod[123:60];
    end
    for (int k = 0; k < ROM_DEPTH; k++) begin
      m   = (k >= 256) ? k - 256 : 256 - k;
      e40 = (e[m] + (64'd1 << 19)) >> 20;
      d40 = (64'd1 << 40) + e40;
      num = (k >= 256) ? (64'd65535 << 41) : (64'd65535 * e40 * 64'd2);
      v   = (udiv64(num, d40) + 64'd1) >> 1;
      rom[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
    end
    return rom;
  endfunction

  localparam act_rom_t ACT_ROM = build_act_rom();

endpackage

// File: sv/nms_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing; instantiated by neuron_mac_sigmoid for the weight store.
module nms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/neuron_mac_sigmoid.sv
// Q4.12 perceptron neuron: weight store, multiply-accumulate and sigmoid lookup.
// Depends on nms_pkg (constants, lookup table) and nms_ram (weight store).
// Throughput: one request per cycle, weight writes and samples alike, while s_tready is high.
// After the last sample is taken, the result passes through the weight read, multiply,
// accumulate, bias and saturate, and table read registers before it appears on m_tvalid.
// Reset (rst, synchronous) clears the pipeline, the accumulator, the sample position,
// the bias and the per-slot valid flags, so every weight slot reads as zero at once.
module neuron_mac_sigmoid #(
  parameter int MAX_INPUTS = nms_pkg::MAX_INPUTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [nms_pkg::S_TDATA_W-1:0] s_tdata,  // [3:0] weight_index, [19:4] value, rest zero
  input  logic                          s_tuser,  // [0] op
  input  logic                          s_tlast,  // last
  // Result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [nms_pkg::ACT_W-1:0]     m_tdata,  // [15:0] activation
  output logic                          m_tuser,  // [0] clamped
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nms_pkg::PADDR_W-1:0]   paddr,
  input  logic [nms_pkg::APB_DW-1:0]    pwdata,
  output logic [nms_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int WIDX_W    = nms_pkg::WIDX_W;
  localparam int VAL_W     = nms_pkg::VAL_W;
  localparam int PROD_W    = nms_pkg::PROD_W;
  localparam int ACC_W     = nms_pkg::ACC_W;
  localparam int FRAC_W    = nms_pkg::FRAC_W;
  localparam int ROM_IDX_W = nms_pkg::ROM_IDX_W;
  localparam int APB_DW    = nms_pkg::APB_DW;
  localparam int REG_W     = nms_pkg::REG_W;
  localparam int POS_W     = $clog2(MAX_INPUTS + 1);
  // Width of the pre-activation: sum shifted down, minus the bias.
  localparam int Z_W       = ACC_W - FRAC_W + 1;

  // Request field unpacking.
  logic [WIDX_W-1:0] in_widx;
  logic [VAL_W-1:0]  in_value;
  assign in_widx  = s_tdata[WIDX_W-1:0];
  assign in_value = s_tdata[WIDX_W +: VAL_W];

  // Configuration: only the bias register exists; writes elsewhere are dropped.
  logic [VAL_W-1:0] bias;
  logic [REG_W-1:0] reg_sel;
  assign reg_sel = paddr[nms_pkg::PADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == nms_pkg::REG_BIAS) ?
                   {{(APB_DW-VAL_W){bias[VAL_W-1]}}, bias} : '0;

  // Pipeline handshake. Each stage loads when it is empty or its contents move on, so
  // requests keep flowing while a finished result waits on m_tready, until a last sample backs up.
  logic v1, v2, v3, v4, ov;
  logic last1, last2;
  logic ready_out, ready4, ready3, mv2, mv1;

  assign ready_out = !ov || m_tready;
  assign ready4    = !v4 || ready_out;
  assign ready3    = !v3 || ready4;
  // A non-last sample only folds into the accumulator, so it never waits.
  assign mv2       = v2 && (!last2 || ready3);
  assign mv1       = v1 && (!v2 || mv2);
  assign s_tready  = !v1 || mv1;

  logic acc_in, wr_acc, feed_acc;
  assign acc_in   = s_tvalid && s_tready;
  assign wr_acc   = acc_in && (s_tuser == nms_pkg::OP_WRITE);
  assign feed_acc = acc_in && (s_tuser == nms_pkg::OP_FEED);

  // Sample position and weight read address. Positions past the store wrap to
  // the slot given by the low address bits.
  logic [POS_W-1:0]  pos;
  logic              use0;
  logic [WIDX_W-1:0] rd_addr;
  assign use0    = pos < POS_W'(MAX_INPUTS);
  assign rd_addr = WIDX_W'(pos);

  // Weight store. A slot never written since reset reads as zero through its flag.
  logic [nms_pkg::WSLOTS-1:0] wvalid;
  logic [VAL_W-1:0]           rdata;

  nms_ram #(
    .WIDTH (VAL_W),
    .DEPTH (nms_pkg::WSLOTS)
  ) u_wram (
    .clk   (clk),
    .we    (wr_acc),
    .waddr (in_widx),
    .wdata (in_value),
    .re    (feed_acc),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Stage 1 holds the sample beside the weight coming out of the RAM. A sample
  // past the input limit is zeroed so that it adds nothing.
  logic              wvld1;
  logic signed [VAL_W-1:0] sample1;
  logic signed [VAL_W-1:0] w_eff;
  assign w_eff = wvld1 ? $signed(rdata) : '0;

  // Stage 2: product.
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  assign prod_next = w_eff * sample1;

  // Accumulator update.
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  assign acc_next = acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // Stage 3: finished sum. Stage 4: table index after bias and saturation.
  logic [ACC_W-1:0]     fin;
  logic [Z_W-1:0]       z;
  logic [Z_W-VAL_W:0]   z_hi;
  logic                 clamp_next;
  logic [VAL_W-1:0]     zsat;
  logic [ROM_IDX_W-1:0] idx_next;
  logic [ROM_IDX_W-1:0] idx4;
  logic                 clamp4;

  // Floor shift of the sum is its top bits; then take off the bias.
  assign z = {fin[ACC_W-1], fin[ACC_W-1:FRAC_W]} -
             {{(Z_W-VAL_W){bias[VAL_W-1]}}, bias};
  assign z_hi       = z[Z_W-1:VAL_W-1];
  assign clamp_next = !((&z_hi) || !(|z_hi));
  assign zsat       = clamp_next ? {z[Z_W-1], {(VAL_W-1){!z[Z_W-1]}}} : z[VAL_W-1:0];
  // (z + 32768) >> 7: flip the sign bit and keep the top bits.
  assign idx_next   = {!zsat[VAL_W-1], zsat[VAL_W-2 -: ROM_IDX_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      bias   <= '0;
      wvalid <= '0;
      pos    <= '0;
      acc    <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
      ov     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (reg_sel == nms_pkg::REG_BIAS)) begin
        bias <= pwdata[VAL_W-1:0];
      end

      if (wr_acc) begin
        wvalid[in_widx] <= 1'b1;
      end

      // The position saturates at the limit; a last mark ends the vector anyway.
      if (feed_acc) begin
        if (s_tlast) begin
          pos <= '0;
        end else if (use0) begin
          pos <= pos + POS_W'(1);
        end
      end

      if (s_tready) begin
        v1 <= feed_acc;
      end
      if (feed_acc) begin
        last1   <= s_tlast;
        sample1 <= use0 ? $signed(in_value) : '0;
        wvld1   <= wvalid[rd_addr];
      end

      if (!v2 || mv2) begin
        v2 <= mv1;
      end
      if (mv1) begin
        prod  <= prod_next;
        last2 <= last1;
      end

      if (mv2) begin
        acc <= last2 ? '0 : acc_next;
      end
      if (ready3) begin
        v3 <= mv2 && last2;
      end
      if (mv2 && last2) begin
        fin <= acc_next;
      end

      if (ready4) begin
        v4 <= v3;
      end
      if (v3 && ready4) begin
        idx4   <= idx_next;
        clamp4 <= clamp_next;
      end

      if (ready_out) begin
        ov <= v4;
      end
      if (v4 && ready_out) begin
        m_tdata <= nms_pkg::ACT_ROM[idx4];
        m_tuser <= clamp4;
      end
    end
  end

  assign m_tvalid = ov;

  // The position never runs past the input limit.
  assert property (@(posedge clk) disable iff (rst) pos <= POS_W'(MAX_INPUTS))
    else $error("sample position beyond limit");

  // A completed vector leaves the accumulator cleared.
  assert property (@(posedge clk) disable iff (rst) (mv2 && last2) |=> (acc == '0))
    else $error("accumulator not cleared after last sample");

  // A written weight slot reads as valid from the next cycle on.
  assert property (@(posedge clk) disable iff (rst) wr_acc |=> wvalid[$past(in_widx)])
    else $error("weight slot flag not set after write");

  // A saturated pre-activation lands on one of the two end entries of the table.
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser) |->
      (m_tdata == nms_pkg::ACT_ROM[0] || m_tdata == nms_pkg::ACT_ROM[nms_pkg::ROM_DEPTH-1]))
    else $error("clamped result not at a table end");

  // A result leaving the index stage shows up on the output next cycle.
  assert property (@(posedge clk) disable iff (rst) (v4 && ready_out) |=> m_tvalid)
    else $error("result lost between index stage and output");

endmodule
